/* hdl/escape_time_fractal_step_defines.svh */
// Assertion macros for the escape-time fractal step
`ifndef ESCAPE_TIME_FRACTAL_STEP_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_STEP_DEFINES_SVH
// assert that a implies b in the next cycle
`define ETF_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("label failed");
// assert that a implies b in the same cycle
`define ETF_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("label failed");
`endif

/* hdl/etf_pkg.sv */
// Package: types, constants and saturating arithmetic for the fractal step
package etf_pkg;
  localparam int FracBits = 28;
  localparam int ValueWidth = 32;
  localparam int CountWidth = 16;
  localparam int ProdWidth = 2 * ValueWidth;
  localparam int AddrWidth = 4;

  typedef logic signed [ValueWidth-1:0] val_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [2:0] {
    FormMandel = 3'd0,
    FormCubic = 3'd1,
    FormQuartic = 3'd2,
    FormMandelbar = 3'd3,
    FormJulia = 3'd4,
    FormBuffalo = 3'd5,
    FormShip = 3'd6,
    FormBird = 3'd7
  } formula_e;

  localparam logic [AddrWidth-1:0] RegFormula = 4'h0;
  localparam logic [AddrWidth-1:0] RegScaleRe = 4'h4;
  localparam logic [AddrWidth-1:0] RegScaleIm = 4'h8;

  localparam val_t VMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam val_t VMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam val_t One = val_t'(64'sd1 <<< FracBits);

  function automatic val_t sat_wide(input logic signed [ValueWidth+1:0] w);
    if (w > $signed({{2{1'b0}}, VMax})) return VMax;
    if (w < $signed({{2{1'b1}}, VMin})) return VMin;
    return w[ValueWidth-1:0];
  endfunction

  function automatic val_t qadd(input val_t a, input val_t b);
    return sat_wide({{2{a[ValueWidth-1]}}, a} + {{2{b[ValueWidth-1]}}, b});
  endfunction

  function automatic val_t qsub(input val_t a, input val_t b);
    return sat_wide({{2{a[ValueWidth-1]}}, a} - {{2{b[ValueWidth-1]}}, b});
  endfunction

  function automatic val_t qneg(input val_t a);
    return (a == VMin) ? VMax : -a;
  endfunction

  function automatic val_t qabs(input val_t a);
    return a[ValueWidth-1] ? qneg(a) : a;
  endfunction

  // k*a saturates to the same bound as repeated saturating adds
  function automatic val_t qk(input val_t a, input logic [2:0] k);
    logic signed [ValueWidth+3:0] w;
    w = {{4{a[ValueWidth-1]}}, a} * $signed({2'b0, k});
    if (w > $signed({{4{1'b0}}, VMax})) return VMax;
    if (w < $signed({{4{1'b1}}, VMin})) return VMin;
    return w[ValueWidth-1:0];
  endfunction

  // floor of the product shifted down, saturated
  function automatic val_t qscale(input logic signed [ProdWidth-1:0] p);
    logic signed [ProdWidth-1:0] s;
    s = p >>> FracBits;
    if (s > $signed({{ValueWidth{1'b0}}, VMax})) return VMax;
    if (s < $signed({{ValueWidth{1'b1}}, VMin})) return VMin;
    return s[ValueWidth-1:0];
  endfunction
endpackage

/* hdl/etf_stream_if.sv */
// Valid/ready stream interfaces for requests and results
interface etf_req_if;
  import etf_pkg::*;
  logic valid;
  logic ready;
  val_t z_real;
  val_t z_imag;
  val_t c_real;
  val_t c_imag;
  count_t count_in;
  modport source (output valid, z_real, z_imag, c_real, c_imag, count_in, input ready);
  modport sink (input valid, z_real, z_imag, c_real, c_imag, count_in, output ready);
endinterface

interface etf_res_if;
  import etf_pkg::*;
  logic valid;
  logic ready;
  val_t next_real;
  val_t next_imag;
  count_t count_out;
  modport source (output valid, next_real, next_imag, count_out, input ready);
  modport sink (input valid, next_real, next_imag, count_out, output ready);
endinterface

/* hdl/etf_mul.sv */
// Registered saturating Q-format multiplier: product then scale
module etf_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  etf_pkg::val_t a_i,
  input  etf_pkg::val_t b_i,
  output etf_pkg::val_t p_o
);
  import etf_pkg::*;
  logic signed [ProdWidth-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= ProdWidth'(a_i) * ProdWidth'(b_i);
  end
  assign p_o = qscale(prod_q);
endmodule

/* hdl/escape_time_fractal_step.sv */
// Top level: pipelined escape-time fractal iteration with APB register port
//  channel | dir | fields
//  req     | in  | z_real z_imag c_real c_imag count_in
//  res     | out | next_real next_imag count_out
//  apb     | in  | formula_select julia_scale_re julia_scale_im
// One request per cycle, passing through two multiplier ranks with their
// scale and add stages. The pipeline advances only when the output stage
// is empty or taken, so a stall holds every stage.
// Reset clears valid bits and sets the APB registers to Mandel and unit scale; payload registers have no reset.
`include "escape_time_fractal_step_defines.svh"
module escape_time_fractal_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  etf_req_if.sink                     req,
  etf_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [etf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import etf_pkg::*;
  localparam int NStg = 8;

  formula_e form_q;
  val_t sre_q, sim_q;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q <= FormMandel;
      sre_q <= One;
      sim_q <= One;
    end else if (wr) begin
      unique case (paddr)
        RegFormula: form_q <= formula_e'(pwdata[2:0]);
        RegScaleRe: sre_q <= pwdata;
        RegScaleIm: sim_q <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      RegFormula: prdata = {29'd0, form_q};
      RegScaleRe: prdata = sre_q;
      RegScaleIm: prdata = sim_q;
      default: prdata = '0;
    endcase
  end

  logic [NStg-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[NStg-1] || res.ready;
  assign req.ready = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NStg-2:0], req.valid};
  end

  // stage 1: inputs, rank-1 products
  val_t x1_q, y1_q, cr1_q, ci1_q; count_t n1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= req.z_real; y1_q <= req.z_imag;
      cr1_q <= req.c_real; ci1_q <= req.c_imag; n1_q <= req.count_in;
    end
  end
  val_t xx, yy, xy, cjr, cji;
  etf_mul u_xx (.clk_i, .en_i(adv), .a_i(req.z_real), .b_i(req.z_real), .p_o(xx));
  etf_mul u_yy (.clk_i, .en_i(adv), .a_i(req.z_imag), .b_i(req.z_imag), .p_o(yy));
  etf_mul u_xy (.clk_i, .en_i(adv), .a_i(req.z_real), .b_i(req.z_imag), .p_o(xy));
  etf_mul u_cr (.clk_i, .en_i(adv), .a_i(req.c_real), .b_i(sre_q), .p_o(cjr));
  etf_mul u_ci (.clk_i, .en_i(adv), .a_i(req.c_imag), .b_i(sim_q), .p_o(cji));

  // stage 2: register scaled rank-1 results and derived sums
  val_t x2_q, y2_q, cr2_q, ci2_q, xx2_q, yy2_q, xy2_q, d2_q, ax2_q, ay2_q;
  val_t t3_q, t4_q;
  count_t n2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q <= x1_q; y2_q <= y1_q;
      cr2_q <= (form_q == FormJulia) ? cjr : cr1_q;
      ci2_q <= (form_q == FormJulia) ? cji : ci1_q;
      xx2_q <= xx; yy2_q <= yy; xy2_q <= xy;
      d2_q <= qsub(xx, yy);
      t3_q <= qsub(xx, qk(yy, 3'd3));
      t4_q <= qsub(qk(xx, 3'd3), yy);
      ax2_q <= qabs(x1_q); ay2_q <= qabs(y1_q);
      n2_q <= n1_q;
    end
  end

  // stage 3: rank-2 products
  val_t a2o, b2o, c2o, d2o;
  val_t ma, mb, mc, md, na, nb, nc, nd;
  always_comb begin
    ma = xx2_q; mb = x2_q; mc = x2_q; md = yy2_q;
    na = xx2_q; nb = y2_q; nc = yy2_q; nd = y2_q;
    unique case (form_q)
      FormCubic: begin
        ma = xx2_q; mb = x2_q; mc = x2_q; md = yy2_q;
        na = xx2_q; nb = y2_q; nc = yy2_q; nd = y2_q;
      end
      FormQuartic: begin
        ma = xx2_q; mb = xx2_q; mc = yy2_q; md = yy2_q;
        na = xx2_q; nb = yy2_q; nc = xy2_q; nd = d2_q;
      end
      FormMandelbar: begin
        ma = t3_q; mb = x2_q; mc = t4_q; md = y2_q;
      end
      FormBird: begin
        ma = t3_q; mb = ax2_q; mc = t4_q; md = ay2_q;
      end
      default: ;
    endcase
  end
  etf_mul u_p0 (.clk_i, .en_i(adv), .a_i(ma), .b_i(mb), .p_o(a2o));
  etf_mul u_p1 (.clk_i, .en_i(adv), .a_i(mc), .b_i(md), .p_o(b2o));
  etf_mul u_p2 (.clk_i, .en_i(adv), .a_i(na), .b_i(nb), .p_o(c2o));
  etf_mul u_p3 (.clk_i, .en_i(adv), .a_i(nc), .b_i(nd), .p_o(d2o));
  val_t cr3_q, ci3_q, d3_q, xy3_q; count_t n3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cr3_q <= cr2_q; ci3_q <= ci2_q; d3_q <= d2_q; xy3_q <= xy2_q; n3_q <= n2_q;
    end
  end

  // stage 4: register rank-2 results
  val_t p0_q, p1_q, p2_q, p3_q, cr4_q, ci4_q, d4_q, xy4_q; count_t n4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= a2o; p1_q <= b2o; p2_q <= c2o; p3_q <= d2o;
      cr4_q <= cr3_q; ci4_q <= ci3_q; d4_q <= d3_q; xy4_q <= xy3_q; n4_q <= n3_q;
    end
  end

  // stage 5: combine into z before c
  val_t re5_q, im5_q, cr5_q, ci5_q, qa_q; count_t n5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cr5_q <= cr4_q; ci5_q <= ci4_q; n5_q <= n4_q;
      qa_q <= qadd(p0_q, p1_q);
      unique case (form_q)
        FormMandel, FormJulia: begin
          re5_q <= d4_q; im5_q <= qk(xy4_q, 3'd2);
        end
        FormCubic: begin
          re5_q <= qsub(p0_q, qk(p1_q, 3'd3)); im5_q <= qsub(qk(p2_q, 3'd3), p3_q);
        end
        FormQuartic: begin
          re5_q <= qk(p2_q, 3'd6); im5_q <= p3_q;
        end
        FormMandelbar: begin
          re5_q <= qneg(p0_q); im5_q <= p1_q;
        end
        FormBuffalo: begin
          re5_q <= qabs(d4_q); im5_q <= qk(qabs(xy4_q), 3'd2);
        end
        FormShip: begin
          re5_q <= d4_q; im5_q <= qk(qabs(xy4_q), 3'd2);
        end
        FormBird: begin
          re5_q <= p0_q; im5_q <= p1_q;
        end
        default: begin
          re5_q <= d4_q; im5_q <= xy4_q;
        end
      endcase
    end
  end

  // stage 6: quartic finish, pass others
  val_t re6_q, im6_q, cr6_q, ci6_q; count_t n6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cr6_q <= cr5_q; ci6_q <= ci5_q; n6_q <= n5_q;
      if (form_q == FormQuartic) begin
        re6_q <= qsub(qa_q, re5_q); im6_q <= qk(im5_q, 3'd4);
      end else begin
        re6_q <= re5_q; im6_q <= im5_q;
      end
    end
  end
  // quartic needs x*y*(xx-yy): rank-2 slot p3 holds that product already

  // stage 7: add c and increment the saturating count
  val_t re7_q, im7_q; count_t n7_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      re7_q <= qadd(re6_q, cr6_q); im7_q <= qadd(im6_q, ci6_q);
      n7_q <= (n6_q == '1) ? n6_q : n6_q + 1'b1;
    end
  end

  // stage 8: output register
  val_t re8_q, im8_q; count_t n8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      re8_q <= re7_q; im8_q <= im7_q; n8_q <= n7_q;
    end
  end
  assign res.valid = vld_q[NStg-1];
  assign res.next_real = re8_q;
  assign res.next_imag = im8_q;
  assign res.count_out = n8_q;

  `ETF_ASSERT_NEXT(a_hold, clk_i, rst_ni, res.valid && !res.ready, res.valid && $stable(n8_q))
  `ETF_ASSERT_NOW(a_rdy, clk_i, rst_ni, !res.valid, req.ready)
  `ETF_ASSERT_NEXT(a_fill, clk_i, rst_ni, req.valid && req.ready, vld_q[0])
endmodule
